/* rtl/core/odyp_pkg.sv */
// package for the ordered dither converter: widths, register indexes,
// configuration struct and the 4x4 threshold table
// no dependencies
package odyp_pkg;

    localparam int unsigned SAMPLE_W      = 8;
    localparam int unsigned CODE_W        = 8;
    localparam int unsigned LINE_W        = 13;
    localparam int unsigned THRESH_W      = 4;
    localparam int unsigned CFG_INDEX_W   = 1;
    localparam int unsigned CFG_DATA_W    = LINE_W;
    localparam int unsigned DEF_MAX_WIDTH = 4096;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE       = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH = 1'd1;

    localparam logic [LINE_W-1:0] LINE_WIDTH_RESET = 13'd320;

    typedef struct packed {
        logic              grey;
        logic [LINE_W-1:0] line_width;
    } odyp_cfg_t;

    // bayer threshold at (row, column)
    function automatic logic [THRESH_W-1:0] bayer_thresh(input logic [1:0] row,
                                                         input logic [1:0] col);
        logic [THRESH_W-1:0] d;
        begin
            case ({row, col})
                4'h0:    d = 4'd0;
                4'h1:    d = 4'd8;
                4'h2:    d = 4'd2;
                4'h3:    d = 4'd10;
                4'h4:    d = 4'd12;
                4'h5:    d = 4'd4;
                4'h6:    d = 4'd14;
                4'h7:    d = 4'd6;
                4'h8:    d = 4'd3;
                4'h9:    d = 4'd11;
                4'ha:    d = 4'd1;
                4'hb:    d = 4'd9;
                4'hc:    d = 4'd15;
                4'hd:    d = 4'd7;
                4'he:    d = 4'd13;
                4'hf:    d = 4'd5;
                default: d = 4'd0;
            endcase
            return d;
        end
    endfunction

endpackage

/* rtl/core/odyp_raster.sv */
// raster position tracker: column counter, row phase, threshold select
// depends on odyp_pkg
module odyp_raster #(
    parameter int unsigned MAX_WIDTH = odyp_pkg::DEF_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            frame_start,
    input  odyp_pkg::odyp_cfg_t             cfg,
    output logic [odyp_pkg::THRESH_W-1:0]   thresh
);
    import odyp_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned CMP_W = (COL_W + 1 > LINE_W) ? COL_W + 1 : LINE_W;

    logic [COL_W-1:0] col_reg, col_next, col_cur;
    logic [1:0]       row_reg, row_next, row_cur;
    logic [CMP_W-1:0] col_inc;
    logic             wrap;

    // frame start clears the position before this pixel is converted
    assign col_cur = frame_start ? '0 : col_reg;
    assign row_cur = frame_start ? 2'd0 : row_reg;

    assign thresh = bayer_thresh(row_cur, col_cur[1:0]);

    assign col_inc = CMP_W'(col_cur) + CMP_W'(1);
    assign wrap    = (col_inc >= CMP_W'(cfg.line_width)) || (col_inc >= CMP_W'(MAX_WIDTH));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (wrap)
            begin
                col_next = '0;
                row_next = row_cur + 2'd1;
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= 2'd0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* rtl/core/odyp_convert.sv */
// pixel conversion: dithered palette index or rounded grey level
// depends on odyp_pkg
module odyp_convert (
    input  logic [odyp_pkg::SAMPLE_W-1:0] luma,
    input  logic [odyp_pkg::SAMPLE_W-1:0] chroma_u,
    input  logic [odyp_pkg::SAMPLE_W-1:0] chroma_v,
    input  logic [odyp_pkg::THRESH_W-1:0] thresh,
    input  odyp_pkg::odyp_cfg_t           cfg,
    output logic [odyp_pkg::CODE_W-1:0]   pixel_code
);
    import odyp_pkg::*;

    logic [8:0] y_sum, y_off, u_sum, v_sum, u_off, v_off;
    logic [4:0] y_q;
    logic [3:0] y4;
    logic [3:0] u_q, v_q;
    logic [1:0] u2, v2;
    logic [3:0] grey;

    assign y_sum = 9'(luma) + 9'(thresh);
    assign y_off = y_sum - 9'd8;
    assign y_q   = y_off[8:4];

    always_comb
    begin
        if (y_sum < 9'd40)
            y4 = 4'd2;
        else if (y_q > 5'd14)
            y4 = 4'd14;
        else
            y4 = y_q[3:0];
    end

    assign u_sum = 9'(chroma_u) + {4'd0, thresh, 1'b0};
    assign v_sum = 9'(chroma_v) + {4'd0, thresh, 1'b0};
    assign u_off = u_sum - 9'd80;
    assign v_off = v_sum - 9'd80;
    assign u_q   = u_off[8:5];
    assign v_q   = v_off[8:5];

    always_comb
    begin
        if (u_sum < 9'd80)
            u2 = 2'd0;
        else if (u_q > 4'd3)
            u2 = 2'd3;
        else
            u2 = u_q[1:0];

        if (v_sum < 9'd80)
            v2 = 2'd0;
        else if (v_q > 4'd3)
            v2 = 2'd3;
        else
            v2 = v_q[1:0];
    end

    // round up when the low nibble is above eight, saturating at 15
    assign grey = ((luma[3:0] > 4'd8) && (luma[7:4] != 4'hf)) ? luma[7:4] + 4'd1 : luma[7:4];

    assign pixel_code = cfg.grey ? {4'd0, grey} : {y4, u2, v2};

endmodule

/* rtl/core/ordered_dither_yuv_to_palette.sv */
// top level of the ordered dither yuv to palette converter
// depends on odyp_pkg, odyp_raster, odyp_convert
//
// channel  | signals                                  | direction | handshake
// ---------+------------------------------------------+-----------+-----------------
// pixel in | in_valid in_stall luma chroma_u/v        | input     | valid and !stall
//          | frame_start                              |           |
// code out | out_valid out_stall pixel_code           | output    | valid and !stall
// config   | cfg_valid cfg_ready cfg_index cfg_data   | input     | valid and ready
//
// one word per clock sustained while out_stall stays low; a word taken sits in the input register,
// the conversion logic then loads its code into the result register, and the code leaves
// from the result register when out_valid is high and out_stall is low
// the threshold is chosen from the raster position when the word is taken
// reset clears the position, the valid flags, mode to colour and line width to 320
// a stall on the output holds the result; the input register takes one more word if it is empty,
// after which in_stall follows out_stall
module ordered_dither_yuv_to_palette #(
    parameter int unsigned MAX_WIDTH = odyp_pkg::DEF_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // pixel input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [odyp_pkg::SAMPLE_W-1:0]     luma,
    input  logic [odyp_pkg::SAMPLE_W-1:0]     chroma_u,
    input  logic [odyp_pkg::SAMPLE_W-1:0]     chroma_v,
    input  logic                              frame_start,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [odyp_pkg::CODE_W-1:0]       pixel_code,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [odyp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [odyp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import odyp_pkg::*;

    // configuration registers
    logic              grey_reg;
    logic [LINE_W-1:0] line_width_reg;
    odyp_cfg_t         cfg;

    // input register stage
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] luma_reg, cu_reg, cv_reg;
    logic [THRESH_W-1:0] thresh_reg;

    // result register stage
    logic                out_valid_reg;
    logic [CODE_W-1:0]   pixel_code_reg;

    logic                out_free;
    logic                s1_move;
    logic                in_take;
    logic [THRESH_W-1:0] thresh;
    logic [CODE_W-1:0]   code_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grey_reg       <= 1'b0;
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:       grey_reg       <= cfg_data[0];
                REG_LINE_WIDTH: line_width_reg <= cfg_data[LINE_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg.grey       = grey_reg;
    assign cfg.line_width = line_width_reg;

    // result register can load when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    // input register can load when empty or moving on
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // raster position advances once for every word taken
    odyp_raster #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_raster (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (in_take),
        .frame_start (frame_start),
        .cfg         (cfg),
        .thresh      (thresh)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            luma_reg   <= luma;
            cu_reg     <= chroma_u;
            cv_reg     <= chroma_v;
            thresh_reg <= thresh;
        end
    end

    odyp_convert u_convert (
        .luma       (luma_reg),
        .chroma_u   (cu_reg),
        .chroma_v   (cv_reg),
        .thresh     (thresh_reg),
        .cfg        (cfg),
        .pixel_code (code_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
            pixel_code_reg <= code_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_code = pixel_code_reg;

endmodule

/* tb/sv/dither_code_monitor.sv */
// monitor for the ordered dither converter: tracks the raster position and the
// register settings, predicts each pixel code and compares results in order
// depends on odyp_pkg
module dither_code_monitor #(
    parameter int unsigned MAX_WIDTH = odyp_pkg::DEF_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [odyp_pkg::SAMPLE_W-1:0]     luma,
    input  logic [odyp_pkg::SAMPLE_W-1:0]     chroma_u,
    input  logic [odyp_pkg::SAMPLE_W-1:0]     chroma_v,
    input  logic                              frame_start,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [odyp_pkg::CODE_W-1:0]       pixel_code,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [odyp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [odyp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                mismatches,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import odyp_pkg::*;

    // 4x4 threshold matrix, nibble (row * 4 + column), row 0 in the low bits
    localparam logic [63:0] BAYER_NIBBLES = 64'h5D7F_91B3_6E4C_A280;
    localparam int          REPORT_LIMIT  = 10;

    logic              grey_mode;
    logic [LINE_W-1:0] line_width;
    int                col_pos;
    int                row_pos;
    int                next_col;
    logic [CODE_W-1:0] want;
    logic [CODE_W-1:0] expected_codes[$];

    function automatic logic [CODE_W-1:0] predict_code(input logic [SAMPLE_W-1:0] y,
                                                       input logic [SAMPLE_W-1:0] cb,
                                                       input logic [SAMPLE_W-1:0] cr);
        int         d;
        int         y4;
        int         u2;
        int         v2;
        logic [3:0] g;
        if (grey_mode)
        begin
            g = y[7:4];
            if (y[3:0] > 4'd8 && g != 4'hF)
                g = g + 4'd1;
            return {4'd0, g};
        end
        d  = BAYER_NIBBLES[16 * row_pos + 4 * (col_pos & 3) +: 4];
        y4 = (int'(y) + d - 8) >>> 4;
        y4 = (y4 < 2) ? 2 : ((y4 > 14) ? 14 : y4);
        u2 = (int'(cb) + 2 * d - 80) >>> 5;
        u2 = (u2 < 0) ? 0 : ((u2 > 3) ? 3 : u2);
        v2 = (int'(cr) + 2 * d - 80) >>> 5;
        v2 = (v2 < 0) ? 0 : ((v2 > 3) ? 3 : v2);
        return {y4[3:0], u2[1:0], v2[1:0]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grey_mode  = 1'b0;
            line_width = LINE_WIDTH_RESET;
            col_pos    = 0;
            row_pos    = 0;
            expected_codes.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            // result side first: a word taken at this edge cannot leave at it
            if (out_valid && !out_stall)
            begin
                if (expected_codes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: pixel_code %0d with nothing expected", $realtime,
                                 pixel_code);
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (pixel_code !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: pixel_code expected %0d got %0d", $realtime,
                                     want, pixel_code);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MODE)
                    grey_mode = cfg_data[0];
                else if (cfg_index == REG_LINE_WIDTH)
                    line_width = cfg_data;
            end

            if (in_valid && !in_stall)
            begin
                if (frame_start)
                begin
                    col_pos = 0;
                    row_pos = 0;
                end
                expected_codes.push_back(predict_code(luma, chroma_u, chroma_v));
                next_col = col_pos + 1;
                if (next_col >= int'(line_width) || next_col >= int'(MAX_WIDTH))
                begin
                    col_pos = 0;
                    row_pos = (row_pos + 1) & 3;
                end
                else
                    col_pos = next_col;
            end

            pending = expected_codes.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
// top of the ordered dither converter testbench: clock, reset, pixel stimulus,
// register writes, random back-pressure and the final verdict
// depends on odyp_pkg, dither_code_monitor and ordered_dither_yuv_to_palette
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import odyp_pkg::*;

    // no word moving on any channel for this long means the block has hung
    localparam int WATCHDOG_LIMIT = 2000;
    // the receiver's one long hold-off, long enough to back the block up
    localparam int HOLD_CYCLES    = 120;
    // two register stages inside; the settle wait covers anything still in flight
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [SAMPLE_W-1:0]    luma        = '0;
    logic [SAMPLE_W-1:0]    chroma_u    = '0;
    logic [SAMPLE_W-1:0]    chroma_v    = '0;
    logic                   frame_start = 1'b0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [CODE_W-1:0]      pixel_code;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index   = REG_MODE;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;

    int mismatches;
    int pending;
    int idle_cycles = 0;

    // knobs the stimulus flips per phase: quiet means no gaps on that side
    bit in_quiet  = 1'b0;
    bit out_quiet = 1'b0;
    bit long_hold = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ordered_dither_yuv_to_palette uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .luma        (luma),
        .chroma_u    (chroma_u),
        .chroma_v    (chroma_v),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_code  (pixel_code),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // watches all three channels beside the block and keeps the score
    dither_code_monitor monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .luma        (luma),
        .chroma_u    (chroma_u),
        .chroma_v    (chroma_v),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_code  (pixel_code),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // gap lengths: mostly short, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(99) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // luma biased towards the clamp and rounding boundaries
    function automatic logic [SAMPLE_W-1:0] pick_luma();
        if ($urandom_range(3) != 0)
            return SAMPLE_W'($urandom);
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd8;
            2:       return 8'd9;
            3:       return 8'd15;
            4:       return 8'd39;
            5:       return 8'd40;
            6:       return 8'd247;
            7:       return 8'd248;
            8:       return 8'd249;
            default: return 8'd255;
        endcase
    endfunction

    // chroma biased towards the level boundaries set by the 80 offset
    function automatic logic [SAMPLE_W-1:0] pick_chroma();
        if ($urandom_range(3) != 0)
            return SAMPLE_W'($urandom);
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd79;
            2:       return 8'd80;
            3:       return 8'd111;
            4:       return 8'd128;
            5:       return 8'd175;
            6:       return 8'd176;
            default: return 8'd255;
        endcase
    endfunction

    // offer one pixel word, after an optional idle gap, and hold it until taken;
    // returns just after the accepting rising edge
    task automatic send_pixel(input logic [SAMPLE_W-1:0] y, input logic [SAMPLE_W-1:0] cb,
                              input logic [SAMPLE_W-1:0] cr, input logic fs);
        int gap;
        gap = (!in_quiet && $urandom_range(99) < 25) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        luma        <= y;
        chroma_u    <= cb;
        chroma_v    <= cr;
        frame_start <= fs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // random pixels; fs_odds of zero means no frame starts at all
    task automatic run_pixels(input int count, input int fs_odds);
        logic fs;
        for (int i = 0; i < count; i++)
        begin
            fs = (fs_odds > 0) && ($urandom_range(fs_odds - 1) == 0);
            send_pixel(pick_luma(), pick_chroma(), pick_chroma(), fs);
        end
    endtask

    // stop offering and wait until every predicted code has come back,
    // plus the SETTLE_CYCLES wait so nothing is still in flight inside
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // registers only change once the block has gone quiet
    task automatic configure(input logic grey, input logic [LINE_W-1:0] width);
        drain();
        write_reg(REG_MODE, CFG_DATA_W'(grey));
        write_reg(REG_LINE_WIDTH, width);
    endtask

    // receiver: random stall runs, quiet stretches, and one long hold-off while
    // the sender keeps pushing so the block fills and stalls its input
    initial
    begin
        int stall_run;
        stall_run = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (stall_run > 0)
            begin
                out_stall <= 1'b1;
                stall_run--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!out_quiet && $urandom_range(99) < 20)
                    stall_run = pick_gap();
            end
        end
    end

    // watchdog: counts cycles with no word moving anywhere
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ordered_dither_yuv_to_palette: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings first (colour, 320 wide), clamps at both ends
        send_pixel(8'd0,   8'd0,   8'd0,   1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd39,  8'd79,  8'd80,  1'b0);
        send_pixel(8'd40,  8'd176, 8'd175, 1'b0);
        // frame start in mid line pulls the threshold back to row 0 column 0
        send_pixel(8'd8,   8'd128, 8'd128, 1'b1);
        send_pixel(8'd247, 8'd0,   8'd255, 1'b0);

        // greyscale: rounding just either side of the half step, saturation at 15,
        // chroma ignored
        configure(1'b1, 13'd2);
        send_pixel(8'h08, 8'd255, 8'd0,   1'b0);
        send_pixel(8'h09, 8'd0,   8'd255, 1'b0);
        send_pixel(8'hF8, 8'd128, 8'd128, 1'b0);
        send_pixel(8'hF9, 8'd255, 8'd255, 1'b0);
        send_pixel(8'hEF, 8'd0,   8'd0,   1'b0);
        send_pixel(8'h00, 8'd77,  8'd200, 1'b0);
        send_pixel(8'h19, 8'd13,  8'd99,  1'b0);

        // zero line width behaves as one pixel per line
        configure(1'b0, 13'd0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd16,  8'd80,  8'd81,  1'b0);
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        send_pixel(8'd1,   8'd254, 8'd1,   1'b0);

        // widest register value, above the maximum width at which lines wrap instead
        configure(1'b0, 13'd8191);
        send_pixel(8'd100, 8'd200, 8'd50,  1'b1);
        send_pixel(8'd200, 8'd50,  8'd100, 1'b0);
        send_pixel(8'd55,  8'd155, 8'd255, 1'b0);

        // random phases over several widths and both modes
        configure(1'b0, 13'd4);
        run_pixels(300, 60);

        // back-pressure: sender never pauses while the receiver holds off
        configure(1'b0, 13'd3);
        in_quiet  = 1'b1;
        long_hold = 1'b1;
        run_pixels(250, 80);
        in_quiet  = 1'b0;

        configure(1'b1, 13'd2);
        out_quiet = 1'b1;
        run_pixels(200, 50);
        out_quiet = 1'b0;

        configure(1'b0, 13'd1);
        run_pixels(150, 60);

        configure(1'b0, 13'd0);
        run_pixels(150, 60);

        // full rate stretch with no idling either side, then gaps again
        configure(1'b0, 13'd13);
        in_quiet  = 1'b1;
        out_quiet = 1'b1;
        run_pixels(150, 0);
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
        run_pixels(150, 70);

        // narrower width while the column may sit past it: the line must end at once
        configure(1'b0, 13'd5);
        run_pixels(100, 0);

        // widest register value: a long run of greyscale pixels at full rate with the
        // column counting well past the earlier widths, then colour to see the row
        // phase and column it left behind
        configure(1'b1, 13'd8191);
        in_quiet  = 1'b1;
        out_quiet = 1'b1;
        send_pixel(pick_luma(), pick_chroma(), pick_chroma(), 1'b1);
        run_pixels(120, 0);
        drain();
        write_reg(REG_MODE, CFG_DATA_W'(1'b0));
        run_pixels(100, 0);
        in_quiet  = 1'b0;
        out_quiet = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("ordered_dither_yuv_to_palette: match");
        else
            $display("ordered_dither_yuv_to_palette: mismatch");
        $finish;
    end

endmodule
